@@ design/mpa_pkg.sv @@
// types and constants shared by the max pooling block
// no dependencies

package mpa_pkg;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               final_sample;
  } in_t;

  typedef struct packed {
    logic signed [15:0] max_value;
    logic [15:0]        source_index;
    logic               found;
    logic [7:0]         out_row;
    logic [7:0]         out_col;
    logic               run_last;
  } out_t;

  typedef enum logic [2:0] {
    REG_PLANE_WIDTH   = 3'd0,
    REG_PLANE_HEIGHT  = 3'd1,
    REG_POOLED_WIDTH  = 3'd2,
    REG_POOLED_HEIGHT = 3'd3,
    REG_WINDOW_WIDTH  = 3'd4,
    REG_WINDOW_HEIGHT = 3'd5,
    REG_STEP_X        = 3'd6,
    REG_STEP_Y        = 3'd7
  } reg_idx_t;

  localparam logic signed [15:0] SAMPLE_MIN  = 16'sh8000;
  localparam logic [15:0]        NO_INDEX    = 16'hFFFF;
  localparam int                 MAX_RESULTS = 64;
  localparam int                 STEP_MAX    = 15;
  // store word: found, index, max
  localparam int                 ENTRY_W     = 33;

endpackage

@@ design/mpa_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module mpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/max_pool_2d_with_argmax.sv @@
// max pooling with argmax over a raster stream of feature planes
// depends on mpa_pkg and mpa_ram
//
// in_*  : one sample request per accepted item (valid/ready), planes back to back
// out_* : one request per completed pooling window, in window completion order;
//         run_last marks the final result caused by a sample
// cfg_* : apb-style register port, register i at byte address 4*i, pready tied high
// After reset the window store is swept to its open value, one entry a cycle,
// with in_ready low; register writes are taken. Per sample: an accept step, two
// bit-serial divisions by the strides (row base, column base), then a step for
// each of the MAX_WINDOW candidate window rows and, for every row that overlaps
// the sample, a step for each of its MAX_WINDOW candidate columns plus one
// read-modify-write step per overlapping window, then a closing step. The store
// memory port and the shared divider keep these steps serial. Results wait in a
// one-deep holding register and an output register; if the receiver stalls, the
// sample in flight waits at its next result and no further sample is taken until
// its last result has moved to the output register.

module max_pool_2d_with_argmax
  import mpa_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_WINDOW = 8,
  parameter int PAD_X      = 0,
  parameter int PAD_Y      = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int AW    = $clog2(MAXD + 16) + 6;
  localparam int QW    = $clog2(MAXD + 8);
  localparam int DSW   = $clog2(((MAX_WINDOW > STEP_MAX) ? MAX_WINDOW : STEP_MAX) + 1);
  localparam int QCW   = $clog2(QW + 1);
  localparam int RPW   = $clog2(MAX_HEIGHT);
  localparam int CPW   = $clog2(MAX_WIDTH);
  localparam int KW    = $clog2(MAX_WINDOW);
  localparam int DEPTH = MAX_WINDOW * MAX_WIDTH;
  localparam int SW    = $clog2(DEPTH);
  localparam int NW    = $clog2(MAX_RESULTS + 1);
  localparam int RS    = QW + KW;
  localparam int RCP   = (2 ** RS + MAX_WINDOW - 1) / MAX_WINDOW;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DIV_R, ST_DIV_C, ST_ROW, ST_COL, ST_WB, ST_FIN
  } state_t;

  // registers
  logic [8:0] plane_width_r, plane_height_r, pooled_width_r, pooled_height_r;
  logic [3:0] window_width_r, window_height_r, step_x_r, step_y_r;

  state_t                st_r;
  logic [SW-1:0]         clr_cnt_r;
  logic [RPW-1:0]        row_pos_r;
  logic [CPW-1:0]        col_pos_r;
  logic signed [15:0]    sample_r;
  logic                  fin_r;
  logic signed [AW-1:0]  r_r, c_r;
  logic [15:0]           idx_r;
  logic [QW-1:0]         div_q_r;
  logic [DSW-1:0]        div_rem_r, div_dvs_r;
  logic [QCW-1:0]        div_cnt_r;
  logic [QW-1:0]         base_r_r, base_c_r;
  logic [DSW-1:0]        brm_r;
  logic [KW-1:0]         kr_r, kc_r;
  logic signed [AW-1:0]  hs_c_r, he_r, ph_r;
  logic [KW-1:0]         phm_r;
  logic signed [AW-1:0]  pw_r;
  logic                  open_r, emit_r;
  logic [SW-1:0]         addr_r;
  logic [NW-1:0]         n_r;
  logic                  pend_valid_r;
  out_t                  pend_r;
  logic                  out_valid_r;
  out_t                  out_r;

  // effective configuration
  logic signed [AW-1:0] w_e, h_e, pwd_e, phd_e, ww_e, wh_e, sx_e, sy_e;

  always_comb begin
    w_e   = $signed({{(AW-9){1'b0}}, plane_width_r});
    h_e   = $signed({{(AW-9){1'b0}}, plane_height_r});
    pwd_e = $signed({{(AW-9){1'b0}}, pooled_width_r});
    phd_e = $signed({{(AW-9){1'b0}}, pooled_height_r});
    ww_e  = $signed({{(AW-4){1'b0}}, window_width_r});
    wh_e  = $signed({{(AW-4){1'b0}}, window_height_r});
    sx_e  = $signed({{(AW-4){1'b0}}, step_x_r});
    sy_e  = $signed({{(AW-4){1'b0}}, step_y_r});
    if (w_e < 1) w_e = AW'(1);
    if (w_e > MAX_WIDTH) w_e = AW'(MAX_WIDTH);
    if (h_e < 1) h_e = AW'(1);
    if (h_e > MAX_HEIGHT) h_e = AW'(MAX_HEIGHT);
    if (pwd_e > MAX_WIDTH) pwd_e = AW'(MAX_WIDTH);
    if (phd_e > MAX_HEIGHT) phd_e = AW'(MAX_HEIGHT);
    if (ww_e < 1) ww_e = AW'(1);
    if (ww_e > MAX_WINDOW) ww_e = AW'(MAX_WINDOW);
    if (wh_e < 1) wh_e = AW'(1);
    if (wh_e > MAX_WINDOW) wh_e = AW'(MAX_WINDOW);
    if (sx_e < 1) sx_e = AW'(1);
    if (sy_e < 1) sy_e = AW'(1);
  end

  // configuration port
  logic cfg_wr;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    case (reg_idx_t'(cfg_paddr[4:2]))
      REG_PLANE_WIDTH:   cfg_prdata = {23'd0, plane_width_r};
      REG_PLANE_HEIGHT:  cfg_prdata = {23'd0, plane_height_r};
      REG_POOLED_WIDTH:  cfg_prdata = {23'd0, pooled_width_r};
      REG_POOLED_HEIGHT: cfg_prdata = {23'd0, pooled_height_r};
      REG_WINDOW_WIDTH:  cfg_prdata = {28'd0, window_width_r};
      REG_WINDOW_HEIGHT: cfg_prdata = {28'd0, window_height_r};
      REG_STEP_X:        cfg_prdata = {28'd0, step_x_r};
      REG_STEP_Y:        cfg_prdata = {28'd0, step_y_r};
      default:           cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_width_r   <= 9'd8;
      plane_height_r  <= 9'd8;
      pooled_width_r  <= 9'd4;
      pooled_height_r <= 9'd4;
      window_width_r  <= 4'd2;
      window_height_r <= 4'd2;
      step_x_r        <= 4'd2;
      step_y_r        <= 4'd2;
    end else if (cfg_wr) begin
      case (reg_idx_t'(cfg_paddr[4:2]))
        REG_PLANE_WIDTH:   plane_width_r   <= cfg_pwdata[8:0];
        REG_PLANE_HEIGHT:  plane_height_r  <= cfg_pwdata[8:0];
        REG_POOLED_WIDTH:  pooled_width_r  <= cfg_pwdata[8:0];
        REG_POOLED_HEIGHT: pooled_height_r <= cfg_pwdata[8:0];
        REG_WINDOW_WIDTH:  window_width_r  <= cfg_pwdata[3:0];
        REG_WINDOW_HEIGHT: window_height_r <= cfg_pwdata[3:0];
        REG_STEP_X:        step_x_r        <= cfg_pwdata[3:0];
        REG_STEP_Y:        step_y_r        <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  // sample position, wrapped to the current plane size
  logic signed [AW-1:0] r_w, c_w;
  logic [15:0]          idx_c;

  always_comb begin
    r_w = $signed({{(AW-RPW){1'b0}}, row_pos_r});
    c_w = $signed({{(AW-CPW){1'b0}}, col_pos_r});
    if (r_w >= h_e) r_w = '0;
    if (c_w >= w_e) c_w = '0;
    idx_c = 16'(16'(r_w) * 16'(w_e) + 16'(c_w));
  end

  // shared restoring divider, one quotient bit a cycle
  logic [DSW:0]   div_sh;
  logic           div_bit;
  logic [DSW-1:0] div_rem_nxt;
  logic [QW-1:0]  div_q_nxt;
  logic           div_done;

  always_comb begin
    div_sh      = {div_rem_r, div_q_r[QW-1]};
    div_bit     = (div_sh >= {1'b0, div_dvs_r});
    div_rem_nxt = div_bit ? DSW'(div_sh - {1'b0, div_dvs_r}) : div_sh[DSW-1:0];
    div_q_nxt   = {div_q_r[QW-2:0], div_bit};
    div_done    = (div_cnt_r == QCW'(QW - 1));
  end

  // row base modulo MAX_WINDOW by reciprocal multiplication
  logic [QW+RS:0] brm_prod;
  logic [QW-1:0]  brm_quo, brm_c;

  always_comb begin
    brm_prod = (QW+RS+1)'(base_r_r) * (QW+RS+1)'(RCP);
    brm_quo  = QW'(brm_prod >> RS);
    brm_c    = base_r_r - QW'(brm_quo * MAX_WINDOW);
  end

  // candidate window row
  logic signed [AW-1:0] kr_s, ph_c, hs_c, hs_cl, he_c, phm_t;
  logic                 row_ok;

  always_comb begin
    kr_s   = $signed({{(AW-KW){1'b0}}, kr_r});
    ph_c   = $signed({{(AW-QW){1'b0}}, base_r_r}) - kr_s;
    hs_c   = ph_c * sy_e - AW'(PAD_Y);
    row_ok = (ph_c >= 0) && (ph_c < phd_e) && (r_r < hs_c + wh_e);
    he_c   = (hs_c + wh_e < h_e) ? hs_c + wh_e : h_e;
    hs_cl  = (hs_c < 0) ? '0 : hs_c;
    phm_t  = $signed({{(AW-DSW){1'b0}}, brm_r}) - kr_s;
    if (phm_t < 0) phm_t = phm_t + AW'(MAX_WINDOW);
  end

  // candidate window column
  logic signed [AW-1:0] pw_c, ws_c, ws_cl, we_c;
  logic                 col_ok, open_c, emit_c;
  logic [SW-1:0]        addr_c;

  always_comb begin
    pw_c   = $signed({{(AW-QW){1'b0}}, base_c_r}) - $signed({{(AW-KW){1'b0}}, kc_r});
    ws_c   = pw_c * sx_e - AW'(PAD_X);
    col_ok = (pw_c >= 0) && (pw_c < pwd_e) && (c_r < ws_c + ww_e);
    we_c   = (ws_c + ww_e < w_e) ? ws_c + ww_e : w_e;
    ws_cl  = (ws_c < 0) ? '0 : ws_c;
    open_c = (r_r == hs_c_r) && (c_r == ws_cl);
    emit_c = (r_r == he_r - 1) && (c_r == we_c - 1);
    addr_c = SW'(SW'(phm_r) * SW'(MAX_WIDTH) + SW'(pw_c[CPW-1:0]));
  end

  // store access
  logic                ram_we, ram_re;
  logic [SW-1:0]       ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;

  mpa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr_c),
    .rdata (ram_rdata)
  );

  // read-modify-write of one entry
  logic signed [15:0] cur_max;
  logic               cur_found;
  logic [15:0]        cur_idx;
  logic               upd;
  logic [ENTRY_W-1:0] new_entry;
  logic               out_free, wb_go, do_emit, out_load;
  out_t               res_c;
  out_t               out_nxt;

  always_comb begin
    cur_max   = open_r ? SAMPLE_MIN : $signed(ram_rdata[15:0]);
    cur_idx   = open_r ? 16'd0 : ram_rdata[31:16];
    cur_found = open_r ? 1'b0 : ram_rdata[32];
    upd       = (sample_r > cur_max);
    new_entry = upd ? {1'b1, idx_r, sample_r} : {cur_found, cur_idx, cur_max};
    out_free  = !out_valid_r || out_ready;
    do_emit   = emit_r && (n_r < NW'(MAX_RESULTS));
    wb_go     = !do_emit || !pend_valid_r || out_free;
    res_c.max_value    = $signed(new_entry[15:0]);
    res_c.found        = new_entry[32];
    res_c.source_index = new_entry[32] ? new_entry[31:16] : NO_INDEX;
    res_c.out_row      = ph_r[7:0];
    res_c.out_col      = pw_r[7:0];
    res_c.run_last     = 1'b0;
    // held result moves to the output register
    out_load = ((st_r == ST_WB) && wb_go && do_emit && pend_valid_r) ||
               ((st_r == ST_FIN) && pend_valid_r && out_free);
    out_nxt          = pend_r;
    out_nxt.run_last = (st_r == ST_FIN);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = new_entry;
    if (st_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = {1'b0, 16'd0, SAMPLE_MIN};
    end else if (st_r == ST_WB && wb_go) begin
      ram_we = 1'b1;
    end
    ram_re = (st_r == ST_COL) && col_ok;
  end

  assign in_ready  = (st_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // next position after the sample
  logic signed [AW-1:0] c_inc, r_inc;
  assign c_inc = c_r + AW'(1);
  assign r_inc = r_r + AW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_CLEAR;
      clr_cnt_r    <= '0;
      row_pos_r    <= '0;
      col_pos_r    <= '0;
      div_cnt_r    <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      n_r          <= '0;
    end else begin
      if (out_load) begin
        out_r       <= out_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == SW'(DEPTH - 1)) st_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid) begin
            sample_r  <= in_data.sample;
            fin_r     <= in_data.final_sample;
            r_r       <= r_w;
            c_r       <= c_w;
            idx_r     <= idx_c;
            n_r       <= '0;
            div_q_r   <= QW'(r_w + AW'(PAD_Y));
            div_rem_r <= '0;
            div_dvs_r <= DSW'(sy_e);
            div_cnt_r <= '0;
            st_r      <= ST_DIV_R;
          end
        end
        ST_DIV_R, ST_DIV_C: begin
          if (!div_done) begin
            div_q_r   <= div_q_nxt;
            div_rem_r <= div_rem_nxt;
            div_cnt_r <= div_cnt_r + 1'b1;
          end else begin
            div_cnt_r <= '0;
            div_rem_r <= '0;
            if (st_r == ST_DIV_R) begin
              base_r_r  <= div_q_nxt;
              div_q_r   <= QW'(c_r + AW'(PAD_X));
              div_dvs_r <= DSW'(sx_e);
              st_r      <= ST_DIV_C;
            end else begin
              base_c_r <= div_q_nxt;
              brm_r    <= DSW'(brm_c);
              kr_r     <= KW'(MAX_WINDOW - 1);
              st_r     <= ST_ROW;
            end
          end
        end
        ST_ROW: begin
          if (row_ok) begin
            hs_c_r <= hs_cl;
            he_r   <= he_c;
            ph_r   <= ph_c;
            phm_r  <= phm_t[KW-1:0];
            kc_r   <= KW'(MAX_WINDOW - 1);
            st_r   <= ST_COL;
          end else if (kr_r == '0) begin
            st_r <= ST_FIN;
          end else begin
            kr_r <= kr_r - 1'b1;
          end
        end
        ST_COL: begin
          if (col_ok) begin
            open_r <= open_c;
            emit_r <= emit_c;
            pw_r   <= pw_c;
            addr_r <= addr_c;
            st_r   <= ST_WB;
          end else if (kc_r != '0) begin
            kc_r <= kc_r - 1'b1;
          end else if (kr_r == '0) begin
            st_r <= ST_FIN;
          end else begin
            kr_r <= kr_r - 1'b1;
            st_r <= ST_ROW;
          end
        end
        ST_WB: begin
          if (wb_go) begin
            if (do_emit) begin
              pend_r       <= res_c;
              pend_valid_r <= 1'b1;
              n_r          <= n_r + 1'b1;
            end
            if (kc_r != '0) begin
              kc_r <= kc_r - 1'b1;
              st_r <= ST_COL;
            end else if (kr_r == '0) begin
              st_r <= ST_FIN;
            end else begin
              kr_r <= kr_r - 1'b1;
              st_r <= ST_ROW;
            end
          end
        end
        ST_FIN: begin
          if (!pend_valid_r || out_free) begin
            pend_valid_r <= 1'b0;
            if (fin_r) begin
              row_pos_r <= '0;
              col_pos_r <= '0;
            end else if (c_inc >= w_e) begin
              col_pos_r <= '0;
              row_pos_r <= (r_inc >= h_e) ? '0 : r_inc[RPW-1:0];
            end else begin
              col_pos_r <= c_inc[CPW-1:0];
              row_pos_r <= r_r[RPW-1:0];
            end
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !pend_valid_r)
    else $error("sample taken with a result still held back");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == ST_WB || st_r == ST_FIN))
    else $error("result raised outside write-back or closing step");

  a_store_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("store read and written in the same cycle");
`endif

endmodule
